[sv/pmftl_pkg.sv]
// ----------------------------------------------------------------------------
// pmftl_pkg
// Shared constants, types and sequencer states of the page-mapped FTL.
// ----------------------------------------------------------------------------
package pmftl_pkg;

    // Geometry
    localparam int NUM_BLOCKS    = 128;
    localparam int PAGES_PER_BLK = 64;
    localparam int LOGICAL_PAGES = 4096;
    localparam int TOTAL_PAGES   = NUM_BLOCKS * PAGES_PER_BLK;

    localparam int BLK_W  = $clog2(NUM_BLOCKS);
    localparam int OFF_W  = $clog2(PAGES_PER_BLK);
    localparam int LPN_W  = $clog2(LOGICAL_PAGES);
    localparam int PP_W   = $clog2(TOTAL_PAGES);
    localparam int CNT_W  = OFF_W + 1;
    localparam int FREE_W = BLK_W + 1;
    localparam int MAPC_W = LPN_W + 1;
    localparam int FPL_W  = FREE_W + OFF_W;
    localparam int STAT_W = 48;

    // Sweep length after reset covers the map and every block row
    localparam int CLR_DEPTH = (LOGICAL_PAGES > NUM_BLOCKS) ? LOGICAL_PAGES : NUM_BLOCKS;
    localparam int IDX_W     = $clog2(CLR_DEPTH + NUM_BLOCKS + PAGES_PER_BLK + 1);

    localparam logic [3:0] GC_THRESHOLD_RST = 4'd3;
    localparam int         REG_GC_THRESHOLD = 0;

    // Per-block bookkeeping word
    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic             full;
        logic [CNT_W-1:0] count;
    } blk_info_t;

    // Logical-to-physical map word
    typedef struct packed {
        logic            mapped;
        logic [PP_W-1:0] pp;
    } map_word_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_OLD,
        S_INV,
        S_PF,
        S_PB,
        S_PW,
        S_GCCHK,
        S_SCAN,
        S_F1,
        S_F2,
        S_F3,
        S_ROW,
        S_MV,
        S_MO,
        S_FIN,
        S_DONE
    } state_t;

endpackage

[sv/page_mapped_ftl_greedy_gc.sv]
// ----------------------------------------------------------------------------
// page_mapped_ftl_greedy_gc
// Page-mapped flash translation layer with greedy garbage collection.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing sweep (one map entry, and until every
// block row is cleared one block row, per cycle) and takes no write until
// it ends; configuration writes are taken throughout. Each host write is
// handled by a sequencer around single-port-per-side RAMs. A write steps
// through map read, old-entry lookup, invalidate (when an old page is
// mapped), fifo read, block read, write, collection check and result. When
// collection is due it adds a scan over the block table, victim checks, a
// pass over every page slot of the victim that relocates its valid pages,
// and a step that frees the victim.
// Results are held in an output register while the next write is accepted.
// ----------------------------------------------------------------------------
module page_mapped_ftl_greedy_gc
    import pmftl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Write requests
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [11:0]  lba,
    // Results
    output logic         out_valid,
    input  logic         out_ready,
    output logic [12:0]  phys_page,
    output logic         gc_ran,
    output logic [6:0]   reclaimed_blk,
    output logic [6:0]   pages_moved,
    output logic         no_victim,
    output logic [12:0]  mapped_count,
    output logic [47:0]  user_writes,
    output logic [47:0]  gc_writes
);

    localparam int ROW_W = PAGES_PER_BLK;

    state_t state_reg, state_next;

    logic [3:0]        thr_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [LPN_W-1:0]  lpn_reg;
    logic              host_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [PP_W-1:0]   oldpp_reg;
    logic [BLK_W-1:0]  head_reg;
    logic [BLK_W-1:0]  tail_reg;
    logic [FREE_W-1:0] free_reg;
    logic [MAPC_W-1:0] mapped_reg;
    logic [STAT_W-1:0] user_reg;
    logic [STAT_W-1:0] gcw_reg;
    logic [PP_W-1:0]   phys_reg;
    logic              gcran_reg;
    logic [BLK_W-1:0]  victim_reg;
    logic [CNT_W-1:0]  moved_reg;
    logic              none_reg;
    logic              found_reg;
    logic [CNT_W-1:0]  best_reg;
    logic [ROW_W-1:0]  vrow_reg;

    logic              out_valid_reg;
    logic [PP_W-1:0]   o_phys_reg;
    logic              o_gcran_reg;
    logic [BLK_W-1:0]  o_victim_reg;
    logic [CNT_W-1:0]  o_moved_reg;
    logic              o_none_reg;
    logic [MAPC_W-1:0] o_mapped_reg;
    logic [STAT_W-1:0] o_user_reg;
    logic [STAT_W-1:0] o_gcw_reg;

    // RAM ports
    logic              map_we;
    logic [LPN_W-1:0]  map_waddr, map_raddr;
    map_word_t         map_wdata, map_rdata;
    logic              row_we;
    logic [BLK_W-1:0]  row_waddr, row_raddr;
    logic [ROW_W-1:0]  row_wdata, row_rdata;
    logic              info_we;
    logic [BLK_W-1:0]  info_waddr, info_raddr;
    blk_info_t         info_wdata, info_rdata;
    logic              fifo_we;
    logic [BLK_W-1:0]  fifo_waddr, fifo_raddr;
    logic [BLK_W-1:0]  fifo_wdata, fifo_rdata;
    logic              own_we;
    logic [PP_W-1:0]   own_waddr, own_raddr;
    logic [LPN_W-1:0]  own_wdata, own_rdata;

    // Derived values
    logic              cfg_wr;
    logic              in_xfer;
    logic              out_free;
    logic [OFF_W-1:0]  off;
    logic [PP_W-1:0]   new_pp;
    logic              blk_fills;
    logic [FPL_W-1:0]  fpl;
    logic              gc_due;
    logic              scan_last;
    logic [BLK_W-1:0]  scan_blk;
    logic              mv_end;
    logic              mv_take;
    logic              clr_end;

    pmftl_ram #(.DEPTH(LOGICAL_PAGES), .WIDTH($bits(map_word_t))) u_map (
        .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    pmftl_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(ROW_W)) u_valid (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata)
    );

    pmftl_ram #(.DEPTH(NUM_BLOCKS), .WIDTH($bits(blk_info_t))) u_info (
        .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
        .raddr(info_raddr), .rdata(info_rdata)
    );

    pmftl_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(BLK_W)) u_fifo (
        .clk(clk), .we(fifo_we), .waddr(fifo_waddr), .wdata(fifo_wdata),
        .raddr(fifo_raddr), .rdata(fifo_rdata)
    );

    pmftl_ram #(.DEPTH(TOTAL_PAGES), .WIDTH(LPN_W)) u_owner (
        .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
        .raddr(own_raddr), .rdata(own_rdata)
    );

    // Handshakes and config port
    assign pready    = 1'b1;
    assign prdata    = {28'd0, thr_reg};
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == 1'(REG_GC_THRESHOLD));
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    assign phys_page     = o_phys_reg;
    assign gc_ran        = o_gcran_reg;
    assign reclaimed_blk = o_victim_reg;
    assign pages_moved   = o_moved_reg;
    assign no_victim     = o_none_reg;
    assign mapped_count  = o_mapped_reg;
    assign user_writes   = o_user_reg;
    assign gc_writes     = o_gcw_reg;

    // Placement, scan and victim helpers
    assign off       = info_rdata.offset;
    assign new_pp    = {blk_reg, off};
    assign blk_fills = (off == OFF_W'(PAGES_PER_BLK - 1));
    assign fpl       = {free_reg, {OFF_W{1'b0}}} - FPL_W'(info_rdata.offset);
    assign gc_due    = (free_reg <= FREE_W'(thr_reg));
    assign scan_last = (idx_reg == IDX_W'(NUM_BLOCKS));
    assign scan_blk  = BLK_W'(idx_reg - IDX_W'(1));
    assign mv_end    = (idx_reg == IDX_W'(PAGES_PER_BLK));
    assign mv_take   = vrow_reg[idx_reg[OFF_W-1:0]] && (free_reg != '0);
    assign clr_end   = (idx_reg == IDX_W'(CLR_DEPTH - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_end) state_next = S_IDLE;
            S_IDLE:  if (in_xfer) state_next = S_MAP;
            S_MAP:   state_next = (free_reg != '0) ? S_OLD : S_GCCHK;
            S_OLD:   state_next = map_rdata.mapped ? S_INV : S_PF;
            S_INV:   state_next = S_PF;
            S_PF:    state_next = S_PB;
            S_PB:    state_next = S_PW;
            S_PW:    state_next = host_reg ? S_GCCHK : S_MV;
            S_GCCHK: state_next = gc_due ? S_SCAN : S_DONE;
            S_SCAN:  if (scan_last) state_next = S_F1;
            S_F1:
            begin
                if (free_reg != '0)
                    state_next = S_F2;
                else if (!found_reg || best_reg != '0)
                    state_next = S_DONE;
                else
                    state_next = S_ROW;
            end
            S_F2:    state_next = S_F3;
            S_F3:
            begin
                if (!found_reg || FPL_W'(best_reg) > fpl)
                    state_next = S_DONE;
                else
                    state_next = S_ROW;
            end
            S_ROW:   state_next = S_MV;
            S_MV:
            begin
                if (mv_end)
                    state_next = S_FIN;
                else if (mv_take)
                    state_next = S_MO;
            end
            S_MO:    state_next = S_PF;
            S_FIN:   state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    // RAM controls
    always_comb
    begin
        map_we     = 1'b0;
        map_waddr  = lpn_reg;
        map_wdata  = '{mapped: 1'b1, pp: new_pp};
        map_raddr  = lpn_reg;
        row_we     = 1'b0;
        row_waddr  = blk_reg;
        row_wdata  = row_rdata | (ROW_W'(1) << off);
        row_raddr  = blk_reg;
        info_we    = 1'b0;
        info_waddr = blk_reg;
        info_wdata = '{offset: off + OFF_W'(1), full: info_rdata.full | blk_fills,
                       count: info_rdata.count + CNT_W'(1)};
        info_raddr = scan_blk;
        fifo_we    = 1'b0;
        fifo_waddr = tail_reg + BLK_W'(1);
        fifo_wdata = victim_reg;
        fifo_raddr = head_reg;
        own_we     = 1'b0;
        own_waddr  = new_pp;
        own_wdata  = lpn_reg;
        own_raddr  = {victim_reg, idx_reg[OFF_W-1:0]};
        unique case (state_reg)
            S_CLEAR:
            begin
                map_we     = (idx_reg < IDX_W'(LOGICAL_PAGES));
                map_waddr  = LPN_W'(idx_reg);
                map_wdata  = '0;
                row_we     = (idx_reg < IDX_W'(NUM_BLOCKS));
                row_waddr  = BLK_W'(idx_reg);
                row_wdata  = '0;
                info_we    = row_we;
                info_waddr = BLK_W'(idx_reg);
                info_wdata = '0;
                fifo_we    = row_we;
                fifo_waddr = BLK_W'(idx_reg);
                fifo_wdata = BLK_W'(idx_reg);
            end
            S_OLD:
            begin
                row_raddr  = map_rdata.pp[PP_W-1 -: BLK_W];
                info_raddr = map_rdata.pp[PP_W-1 -: BLK_W];
            end
            S_INV:
            begin
                row_we     = 1'b1;
                row_waddr  = oldpp_reg[PP_W-1 -: BLK_W];
                row_wdata  = row_rdata & ~(ROW_W'(1) << oldpp_reg[OFF_W-1:0]);
                info_we    = 1'b1;
                info_waddr = oldpp_reg[PP_W-1 -: BLK_W];
                info_wdata = info_rdata;
                if (info_rdata.count != '0)
                    info_wdata.count = info_rdata.count - CNT_W'(1);
            end
            S_PB:
            begin
                row_raddr  = fifo_rdata;
                info_raddr = fifo_rdata;
            end
            S_PW:
            begin
                map_we  = 1'b1;
                row_we  = 1'b1;
                info_we = 1'b1;
                own_we  = 1'b1;
            end
            // Block idx is read now and judged in the next cycle as scan_blk
            S_SCAN:
            begin
                info_raddr = BLK_W'(idx_reg);
            end
            S_F2:
            begin
                info_raddr = fifo_rdata;
            end
            S_F1, S_F3:
            begin
                row_raddr = victim_reg;
            end
            S_FIN:
            begin
                row_we     = 1'b1;
                row_waddr  = victim_reg;
                row_wdata  = '0;
                info_we    = 1'b1;
                info_waddr = victim_reg;
                info_wdata = '0;
                fifo_we    = (free_reg < FREE_W'(NUM_BLOCKS));
            end
            default:
            begin
            end
        endcase
    end

    // Control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            thr_reg       <= GC_THRESHOLD_RST;
            idx_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= BLK_W'(NUM_BLOCKS - 1);
            free_reg      <= FREE_W'(NUM_BLOCKS);
            mapped_reg    <= '0;
            user_reg      <= '0;
            gcw_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
                thr_reg <= pwdata[3:0];
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= clr_end ? '0 : idx_reg + IDX_W'(1);
                end
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        lpn_reg   <= lba;
                        host_reg  <= 1'b1;
                        phys_reg  <= '0;
                        gcran_reg <= 1'b0;
                        victim_reg <= '0;
                        moved_reg <= '0;
                        none_reg  <= 1'b0;
                    end
                end
                S_OLD:
                begin
                    oldpp_reg <= map_rdata.pp;
                    if (map_rdata.mapped && mapped_reg != '0)
                        mapped_reg <= mapped_reg - MAPC_W'(1);
                end
                S_PB:
                begin
                    blk_reg <= fifo_rdata;
                end
                S_PW:
                begin
                    if (blk_fills)
                    begin
                        head_reg <= head_reg + BLK_W'(1);
                        free_reg <= free_reg - FREE_W'(1);
                    end
                    if (host_reg)
                    begin
                        phys_reg   <= new_pp;
                        mapped_reg <= mapped_reg + MAPC_W'(1);
                        if (user_reg != '1)
                            user_reg <= user_reg + STAT_W'(1);
                    end
                    else
                    begin
                        moved_reg <= moved_reg + CNT_W'(1);
                        idx_reg   <= idx_reg + IDX_W'(1);
                        if (gcw_reg != '1)
                            gcw_reg <= gcw_reg + STAT_W'(1);
                    end
                end
                S_GCCHK:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    best_reg  <= '0;
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg != '0 && info_rdata.full &&
                        (!found_reg || info_rdata.count < best_reg))
                    begin
                        found_reg  <= 1'b1;
                        best_reg   <= info_rdata.count;
                        victim_reg <= scan_blk;
                    end
                end
                S_F1:
                begin
                    if (free_reg == '0 && (!found_reg || best_reg != '0))
                    begin
                        none_reg   <= 1'b1;
                        victim_reg <= '0;
                    end
                end
                S_F3:
                begin
                    if (!found_reg || FPL_W'(best_reg) > fpl)
                    begin
                        none_reg   <= 1'b1;
                        victim_reg <= '0;
                    end
                end
                S_ROW:
                begin
                    vrow_reg <= row_rdata;
                    idx_reg  <= '0;
                end
                S_MV:
                begin
                    if (!mv_end && !mv_take)
                        idx_reg <= idx_reg + IDX_W'(1);
                end
                S_MO:
                begin
                    lpn_reg  <= own_rdata;
                    host_reg <= 1'b0;
                end
                S_FIN:
                begin
                    gcran_reg <= 1'b1;
                    if (free_reg < FREE_W'(NUM_BLOCKS))
                    begin
                        tail_reg <= tail_reg + BLK_W'(1);
                        free_reg <= free_reg + FREE_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            o_phys_reg   <= phys_reg;
            o_gcran_reg  <= gcran_reg;
            o_victim_reg <= victim_reg;
            o_moved_reg  <= moved_reg;
            o_none_reg   <= none_reg;
            o_mapped_reg <= mapped_reg;
            o_user_reg   <= user_reg;
            o_gcw_reg    <= gcw_reg;
        end
    end

endmodule

[sv/pmftl_ram.sv]
// ----------------------------------------------------------------------------
// pmftl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pmftl_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
